// ===== rtl/wfa_pkg.sv =====
// ----------------------------------------------------------------------------
// wfa_pkg
// Shared types and constants for the worst-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package wfa_pkg;

    localparam int MAX_BLOCKS = 32;
    localparam int SIZE_BITS  = 16;

    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int COUNT_W = 6;
    localparam int SLOT_W  = 5;
    localparam int AMT_W   = 16;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [SIZE_BITS-1:0] size_t;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    localparam logic [1:0] ST_LOADED = 2'd0;
    localparam logic [1:0] ST_ALLOC  = 2'd1;
    localparam logic [1:0] ST_NOFIT  = 2'd2;
    localparam logic [1:0] ST_RANGE  = 2'd3;

    typedef struct packed {
        logic              operation;
        logic [SLOT_W-1:0] block_slot;
        logic [AMT_W-1:0]  amount;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] chosen_block;
        logic [AMT_W-1:0]  chosen_size;
        logic [AMT_W-1:0]  leftover;
    } result_t;

    // best candidate so far, passed cell to cell
    typedef struct packed {
        logic  valid;
        logic  found;
        idx_t  idx;
        size_t size;
        size_t left;
    } token_t;

    // control broadcast to every cell
    typedef struct packed {
        logic  load_valid;
        idx_t  load_idx;
        size_t load_size;
        logic  mark_valid;
        idx_t  mark_idx;
        size_t amount;
        cnt_t  active_count;
    } bcast_t;

endpackage

`default_nettype wire

// ===== rtl/worst_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// worst_fit_block_allocator
// Worst-fit allocator over a row of block cells.
// ----------------------------------------------------------------------------
// A load's result strobes on done in the next cycle and busy stays low,
// so loads may be issued back to back. An allocate transaction sends a
// candidate token down the row of MAX_BLOCKS cells, one cell per cycle,
// through each cell's token register, and busy is high until the cycle in
// which done strobes. Each result is on result for exactly one cycle while
// done is high and must be taken then. The user must write block_count via
// cfg_we/cfg_wdata only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module worst_fit_block_allocator (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_we,
    input  wire  [wfa_pkg::COUNT_W-1:0]     cfg_wdata,
    input  wire                             start,
    input  wfa_pkg::cmd_t                   cmd,
    output logic                            busy,
    output logic                            done,
    output wfa_pkg::result_t                result
);
    import wfa_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic               scanning_reg;
    logic               scanning_next;
    size_t              amount_reg;
    token_t             launch_reg;
    token_t             launch_next;
    logic               mark_valid_reg;
    idx_t               mark_idx_reg;
    logic               done_reg;
    logic               done_next;
    result_t            result_reg;
    result_t            result_next;

    logic               accept;
    logic               slot_ok;
    size_t              in_size;
    cnt_t               active_count;
    bcast_t             bcast;
    token_t             tok [0:MAX_BLOCKS];
    token_t             tail;

    assign accept  = start && !scanning_reg;
    assign slot_ok = 32'(cmd.block_slot) < MAX_BLOCKS;
    assign in_size = SIZE_BITS'(cmd.amount);

    assign active_count = (32'(count_reg) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS)
                                                         : CNT_W'(count_reg);

    always_comb
    begin
        bcast.load_valid   = accept && (cmd.operation == OP_LOAD) && slot_ok;
        bcast.load_idx     = IDX_W'(cmd.block_slot);
        bcast.load_size    = in_size;
        bcast.mark_valid   = mark_valid_reg;
        bcast.mark_idx     = mark_idx_reg;
        bcast.amount       = amount_reg;
        bcast.active_count = active_count;
    end

    assign tok[0] = launch_reg;

    for (genvar i = 0; i < MAX_BLOCKS; i++)
    begin : g_cell
        wfa_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (IDX_W'(i)),
            .bcast      (bcast),
            .tok_in     (tok[i]),
            .tok_out    (tok[i+1])
        );
    end

    assign tail = tok[MAX_BLOCKS];

    always_comb
    begin
        launch_next       = '0;
        scanning_next     = scanning_reg;
        done_next         = 1'b0;
        result_next       = '0;

        if (accept && (cmd.operation == OP_ALLOC))
        begin
            launch_next.valid = 1'b1;
            scanning_next     = 1'b1;
        end
        else if (accept)
        begin
            done_next = 1'b1;
            if (slot_ok)
            begin
                result_next.status       = ST_LOADED;
                result_next.chosen_block = cmd.block_slot;
                result_next.chosen_size  = AMT_W'(in_size);
            end
            else
            begin
                result_next.status = ST_RANGE;
            end
        end

        if (tail.valid)
        begin
            scanning_next = 1'b0;
            done_next     = 1'b1;
            if (tail.found)
            begin
                result_next.status       = ST_ALLOC;
                result_next.chosen_block = SLOT_W'(tail.idx);
                result_next.chosen_size  = AMT_W'(tail.size);
                result_next.leftover     = AMT_W'(tail.left);
            end
            else
            begin
                result_next.status = ST_NOFIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            scanning_reg   <= 1'b0;
            launch_reg     <= '0;
            mark_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            scanning_reg   <= scanning_next;
            launch_reg     <= launch_next;
            mark_valid_reg <= tail.valid && tail.found;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            amount_reg <= in_size;
        end
        mark_idx_reg <= tail.idx;
        result_reg   <= result_next;
    end

    assign busy   = scanning_reg;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ===== rtl/wfa_cell.sv =====
// ----------------------------------------------------------------------------
// wfa_cell
// One table entry: block size and taken mark. Compares itself against the
// passing best-candidate token and forwards the better of the two.
// ----------------------------------------------------------------------------
`default_nettype none

module wfa_cell (
    input  wire              clk,
    input  wire              rst_n,
    input  wfa_pkg::idx_t    cell_index,
    input  wfa_pkg::bcast_t  bcast,
    input  wfa_pkg::token_t  tok_in,
    output wfa_pkg::token_t  tok_out
);
    import wfa_pkg::*;

    size_t  size_reg;
    logic   taken_reg;
    logic   taken_next;
    token_t tok_reg;
    token_t tok_next;

    logic   active;
    logic   eligible;
    size_t  left;
    logic   take;

    always_comb
    begin
        active   = CNT_W'(cell_index) < bcast.active_count;
        eligible = active && !taken_reg && (size_reg >= bcast.amount);
        left     = size_reg - bcast.amount;
        take     = eligible && (!tok_in.found || (left > tok_in.left));

        tok_next = tok_in;
        if (tok_in.valid && take)
        begin
            tok_next.found = 1'b1;
            tok_next.idx   = cell_index;
            tok_next.size  = size_reg;
            tok_next.left  = left;
        end

        taken_next = taken_reg;
        if (bcast.mark_valid && (bcast.mark_idx == cell_index))
        begin
            taken_next = 1'b1;
        end
        if (bcast.load_valid && (bcast.load_idx == cell_index))
        begin
            taken_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            taken_reg <= taken_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bcast.load_valid && (bcast.load_idx == cell_index))
        begin
            size_reg <= bcast.load_size;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire
